// ===== rtl/pcs_pkg.sv =====
// Shared types and constants for the PID controller step block.
package pcs_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int GAIN_W    = 31;
  localparam int POLE_W    = 18;
  localparam int CFG_IDX_W = 3;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = ((2 * DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + 2 + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_KP         = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_POLE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX  = CFG_IDX_W'(7);

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        int_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic signed [POLE_W-1:0] deriv_pole;
    data_t                    out_min;
    data_t                    out_max;
    data_t                    integ_min;
    data_t                    integ_max;
  } cfg_t;

  typedef struct packed {
    data_t integ_acc;
    data_t last_error;
    data_t deriv_acc;
    data_t last_measured;
  } state_t;

  typedef struct packed {
    data_t drive;
    logic  drive_clamped;
    logic  integ_clamped;
  } result_t;

endpackage

// ===== rtl/pcs_cfg_regs.sv =====
// Configuration register file for the PID controller step block.
module pcs_cfg_regs
  import pcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp         <= '0;
      cfg_r.int_gain   <= '0;
      cfg_r.deriv_gain <= '0;
      cfg_r.deriv_pole <= '0;
      cfg_r.out_min    <= DATA_MIN;
      cfg_r.out_max    <= DATA_MAX;
      cfg_r.integ_min  <= DATA_MIN;
      cfg_r.integ_max  <= DATA_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:         cfg_r.kp         <= cfg_wdata[GAIN_W-1:0];
        REG_INT_GAIN:   cfg_r.int_gain   <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg_r.deriv_gain <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_POLE: cfg_r.deriv_pole <= cfg_wdata[POLE_W-1:0];
        REG_OUT_MIN:    cfg_r.out_min    <= cfg_wdata;
        REG_OUT_MAX:    cfg_r.out_max    <= cfg_wdata;
        REG_INTEG_MIN:  cfg_r.integ_min  <= cfg_wdata;
        REG_INTEG_MAX:  cfg_r.integ_max  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/pcs_datapath.sv =====
// Single-pass PID update: error, three gain products, clamps and next state.
module pcs_datapath
  import pcs_pkg::*;
(
  input  cfg_t   cfg,
  input  state_t state,
  input  data_t  target,
  input  data_t  measured,
  output state_t state_nxt,
  output result_t result
);

  localparam int PROD_W = 2 * DATA_W + 2;
  localparam int Q_W    = PROD_W - FRAC_W;

  // Floor of a product scaled down by the fraction bits, saturated to the data range.
  function automatic data_t mulq_sat(input logic signed [PROD_W-1:0] p);
    logic signed [Q_W-1:0] q;
    logic [Q_W-DATA_W:0]   hi;
    q  = p[PROD_W-1:FRAC_W];
    hi = q[Q_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      return q[DATA_W-1:0];
    end else begin
      return q[Q_W-1] ? DATA_MIN : DATA_MAX;
    end
  endfunction

  function automatic data_t sat1(input logic signed [DATA_W:0] v);
    if (v[DATA_W] != v[DATA_W-1]) begin
      return v[DATA_W] ? DATA_MIN : DATA_MAX;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  logic signed [DATA_W:0]        err_w;
  data_t                         err;
  logic signed [DATA_W:0]        err_sum;
  logic signed [DATA_W:0]        meas_diff;
  logic signed [DATA_W-1:0]      kp_s;
  logic signed [DATA_W-1:0]      ig_s;
  logic signed [DATA_W-1:0]      dg_s;
  logic signed [2*DATA_W-1:0]    prod_p;
  logic signed [2*DATA_W:0]      prod_i;
  logic signed [2*DATA_W:0]      prod_d;
  logic signed [DATA_W+POLE_W-1:0] prod_f;
  data_t                         prop;
  data_t                         integ_inc;
  data_t                         d1;
  data_t                         d2;
  data_t                         deriv;
  data_t                         integ;
  logic signed [DATA_W:0]        integ_w;
  logic signed [DATA_W+1:0]      sum_w;
  data_t                         drive;
  logic                          integ_hit;
  logic                          drive_hit;

  assign err_w     = {target[DATA_W-1], target} - {measured[DATA_W-1], measured};
  assign err       = sat1(err_w);
  assign err_sum   = {err[DATA_W-1], err} + {state.last_error[DATA_W-1], state.last_error};
  assign meas_diff = {measured[DATA_W-1], measured}
                   - {state.last_measured[DATA_W-1], state.last_measured};

  assign kp_s = {{(DATA_W-GAIN_W){1'b0}}, cfg.kp};
  assign ig_s = {{(DATA_W-GAIN_W){1'b0}}, cfg.int_gain};
  assign dg_s = {{(DATA_W-GAIN_W){1'b0}}, cfg.deriv_gain};

  // The four products are independent and run side by side.
  assign prod_p = kp_s * err;
  assign prod_i = ig_s * err_sum;
  assign prod_d = dg_s * meas_diff;
  assign prod_f = $signed(cfg.deriv_pole) * $signed(state.deriv_acc);

  assign prop      = mulq_sat(PROD_W'(prod_p));
  assign integ_inc = mulq_sat(PROD_W'(prod_i));
  assign d1        = mulq_sat(PROD_W'(prod_d));
  assign d2        = mulq_sat(PROD_W'(prod_f));
  assign deriv     = sat1({d2[DATA_W-1], d2} - {d1[DATA_W-1], d1});

  assign integ_w = {state.integ_acc[DATA_W-1], state.integ_acc}
                 + {integ_inc[DATA_W-1], integ_inc};

  // The upper limit is tested first, so it wins for values beyond both limits.
  always_comb begin
    integ_hit = 1'b1;
    if (integ_w > $signed({cfg.integ_max[DATA_W-1], cfg.integ_max})) begin
      integ = cfg.integ_max;
    end else if (integ_w < $signed({cfg.integ_min[DATA_W-1], cfg.integ_min})) begin
      integ = cfg.integ_min;
    end else begin
      integ     = integ_w[DATA_W-1:0];
      integ_hit = 1'b0;
    end
  end

  assign sum_w = {{2{prop[DATA_W-1]}}, prop}
               + {{2{integ[DATA_W-1]}}, integ}
               + {{2{deriv[DATA_W-1]}}, deriv};

  always_comb begin
    drive_hit = 1'b1;
    if (sum_w > $signed({{2{cfg.out_max[DATA_W-1]}}, cfg.out_max})) begin
      drive = cfg.out_max;
    end else if (sum_w < $signed({{2{cfg.out_min[DATA_W-1]}}, cfg.out_min})) begin
      drive = cfg.out_min;
    end else begin
      drive     = sum_w[DATA_W-1:0];
      drive_hit = 1'b0;
    end
  end

  assign state_nxt.integ_acc     = integ;
  assign state_nxt.last_error    = err;
  assign state_nxt.deriv_acc     = deriv;
  assign state_nxt.last_measured = measured;

  assign result.drive         = drive;
  assign result.drive_clamped = drive_hit;
  assign result.integ_clamped = integ_hit;

endmodule

// ===== rtl/pid_controller_step_top.sv =====
// PID controller step with trapezoidal integrator and filtered derivative: top level.
//
// One beat on the input stream is one controller update; it yields exactly one
// output beat. An accepted beat lands in an input register, the whole update
// (error, the four products, clamps and the controller state) is computed
// combinationally from that register and written to the output register
// together with the new state once the output register is empty or being
// drained, and a new beat is taken every cycle while the output side keeps up.
// The rate is one beat per cycle while the output keeps up, set by the state
// feedback through the products and clamps.
// Data values are signed Q16.16, gains unsigned Q15.16 and the pole signed
// Q2.16; products floor toward minus infinity and saturate. Configuration
// registers should be written only while no beat is in flight.
module pid_controller_step_top
  import pcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream tdata: target [31:0], measured [63:32].
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Output stream tdata: drive [31:0], drive_clamped [32], integ_clamped [33], zero pad.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_wdata
);

  cfg_t    cfg;
  state_t  state_r;
  state_t  state_nxt;
  result_t result_nxt;
  result_t result_r;
  logic    in_valid_r;
  data_t   target_r;
  data_t   measured_r;
  logic    out_valid_r;
  logic    advance;

  pcs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcs_datapath u_datapath (
    .cfg       (cfg),
    .state     (state_r),
    .target    (target_r),
    .measured  (measured_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // The held beat moves on when the output register is empty or being drained.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      target_r   <= in_tdata[DATA_W-1:0];
      measured_r <= in_tdata[2*DATA_W-1:DATA_W];
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DATA_W-2){1'b0}}, result_r.integ_clamped,
                       result_r.drive_clamped, result_r.drive};

endmodule

// ===== tb/sv/pid_controller_step_top_test.sv =====
// Self-checking testbench for the PID controller step block.
`timescale 1ns / 1ps

module pid_controller_step_top_test;
  import pcs_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    data_t target;
    data_t measured;
  } sample_t;

  typedef enum {CFG_CALM, CFG_EXTREME, CFG_CROSSED, CFG_WILD} cfg_style_e;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  localparam wide_t W_MAX = DATA_MAX;
  localparam wide_t W_MIN = DATA_MIN;
  localparam int HOLDOFF_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // target [31:0], measured [63:32]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // drive [31:0], drive_clamped [32], integ_clamped [33], zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]      cfg_wdata = '0;

  pid_controller_step_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Controller settings as the block should hold them.
  wide_t g_kp = 0;
  wide_t g_int = 0;
  wide_t g_deriv = 0;
  wide_t pole = 0;
  wide_t lim_out_lo = W_MIN;
  wide_t lim_out_hi = W_MAX;
  wide_t lim_integ_lo = W_MIN;
  wide_t lim_integ_hi = W_MAX;

  // Controller state carried from one update to the next.
  wide_t acc_integ = 0;
  wide_t prev_err = 0;
  wide_t acc_deriv = 0;
  wide_t prev_meas = 0;

  sample_t sample_q[$];
  result_t drive_due[$];
  sample_t next_sample;
  result_t due_now;

  logic in_fire = 1'b0;
  logic holdoff_req = 1'b0;
  logic rx_held = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned n_updates = 0;
  int unsigned n_drives = 0;
  int unsigned n_settings = 0;

  function automatic wide_t sat_data(wide_t v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  // Fixed-point product, floored and saturated to the data range.
  function automatic wide_t mul_q(wide_t a, wide_t b);
    wide_t p;
    p = (a * b) >>> FRAC_W;
    return sat_data(p);
  endfunction

  // The upper limit is tested first, which decides crossed limits.
  function automatic wide_t clamp_to(wide_t v, wide_t lo, wide_t hi, output bit hit);
    hit = 1'b1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    hit = 1'b0;
    return v;
  endfunction

  task automatic pid_update(data_t target, data_t measured);
    wide_t t, m, err, prop, integ, deriv, drive;
    bit ihit, ohit;
    result_t r;
    t = target;
    m = measured;
    err = sat_data(t - m);
    prop = mul_q(g_kp, err);
    integ = clamp_to(acc_integ + mul_q(g_int, err + prev_err), lim_integ_lo, lim_integ_hi,
                     ihit);
    deriv = sat_data(mul_q(pole, acc_deriv) - mul_q(g_deriv, m - prev_meas));
    drive = clamp_to(prop + integ + deriv, lim_out_lo, lim_out_hi, ohit);
    acc_integ = integ;
    acc_deriv = deriv;
    prev_err = err;
    prev_meas = m;
    r.drive = drive[DATA_W-1:0];
    r.drive_clamped = ohit;
    r.integ_clamped = ihit;
    drive_due.push_back(r);
    n_updates++;
  endtask

  task automatic flag_mismatch(string msg);
    // Keep the log short if the block is badly broken.
    if (mismatch_count < 100) $display("%0t ns: MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // Input side: once the previous beat was taken, present a new one unless the sender idles.
  always @(negedge clk) begin
    if (!in_tvalid || in_fire) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = sample_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {next_sample.measured, next_sample.target};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && !rx_held && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    wait (holdoff_req);
    rx_held <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(negedge clk);
    rx_held <= 1'b0;
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      pid_update(in_tdata[DATA_W-1:0], in_tdata[2*DATA_W-1:DATA_W]);
    if (rst_n && out_tvalid && out_tready) begin
      n_drives++;
      if (drive_due.size() == 0) begin
        flag_mismatch($sformatf("result beat with no update pending, tdata %h", out_tdata));
      end else begin
        due_now = drive_due.pop_front();
        if (out_tdata[DATA_W-1:0] !== due_now.drive)
          flag_mismatch($sformatf("beat %0d drive %h, want %h", n_drives,
                                  out_tdata[DATA_W-1:0], due_now.drive));
        if (out_tdata[DATA_W] !== due_now.drive_clamped)
          flag_mismatch($sformatf("beat %0d drive_clamped %b, want %b", n_drives,
                                  out_tdata[DATA_W], due_now.drive_clamped));
        if (out_tdata[DATA_W+1] !== due_now.integ_clamped)
          flag_mismatch($sformatf("beat %0d integ_clamped %b, want %b", n_drives,
                                  out_tdata[DATA_W+1], due_now.integ_clamped));
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_KP:         g_kp = {65'd0, val[GAIN_W-1:0]};
      REG_INT_GAIN:   g_int = {65'd0, val[GAIN_W-1:0]};
      REG_DERIV_GAIN: g_deriv = {65'd0, val[GAIN_W-1:0]};
      REG_DERIV_POLE: pole = $signed(val[POLE_W-1:0]);
      REG_OUT_MIN:    lim_out_lo = $signed(val);
      REG_OUT_MAX:    lim_out_hi = $signed(val);
      REG_INTEG_MIN:  lim_integ_lo = $signed(val);
      REG_INTEG_MAX:  lim_integ_hi = $signed(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_limits(logic [DATA_W-1:0] olo, logic [DATA_W-1:0] ohi,
                              logic [DATA_W-1:0] ilo, logic [DATA_W-1:0] ihi);
    write_reg(REG_OUT_MIN, olo);
    write_reg(REG_OUT_MAX, ohi);
    write_reg(REG_INTEG_MIN, ilo);
    write_reg(REG_INTEG_MAX, ihi);
    n_settings++;
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(3))
      0: return '0;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic program_random(cfg_style_e style);
    logic [DATA_W-1:0] a, b;
    if (style == CFG_EXTREME || style == CFG_WILD) begin
      write_reg(REG_KP, style == CFG_WILD ? $urandom : pick_gain());
      write_reg(REG_INT_GAIN, style == CFG_WILD ? $urandom : pick_gain());
      write_reg(REG_DERIV_GAIN, style == CFG_WILD ? $urandom : pick_gain());
    end else begin
      write_reg(REG_KP, $urandom_range(0, 32'h0002_0000));
      write_reg(REG_INT_GAIN, $urandom_range(0, 32'h0000_4000));
      write_reg(REG_DERIV_GAIN, $urandom_range(0, 32'h0001_0000));
    end
    case (style)
      CFG_EXTREME: begin
        case ($urandom_range(2))
          0: write_reg(REG_DERIV_POLE, -32'sh0001_0000);
          1: write_reg(REG_DERIV_POLE, 32'h0001_0000);
          default: write_reg(REG_DERIV_POLE, $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
        endcase
        a = $urandom;
        b = $urandom;
        if ($urandom_range(1)) write_limits(DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX);
        else if ($signed(a) <= $signed(b)) write_limits(a, b, DATA_MIN, b);
        else write_limits(b, a, b, DATA_MAX);
      end
      CFG_WILD: begin
        // Raw words: bits above each register's width must be dropped.
        write_reg(REG_DERIV_POLE, $urandom);
        write_limits($urandom, $urandom, $urandom, $urandom);
      end
      CFG_CROSSED: begin
        write_reg(REG_DERIV_POLE, $urandom_range(0, 32'h0001_0000));
        write_limits($urandom_range(0, 32'h0040_0000), -$urandom_range(0, 32'h0040_0000),
                     $urandom_range(0, 32'h0020_0000), -$urandom_range(0, 32'h0020_0000));
      end
      default: begin
        write_reg(REG_DERIV_POLE, $urandom_range(0, 32'h0001_0000));
        write_limits(-$urandom_range(32'h0001_0000, 32'h0080_0000),
                     $urandom_range(32'h0001_0000, 32'h0080_0000),
                     -$urandom_range(32'h0001_0000, 32'h0040_0000),
                     $urandom_range(32'h0001_0000, 32'h0040_0000));
      end
    endcase
  endtask

  task automatic push_sample(data_t target, data_t measured);
    sample_t s;
    s.target = target;
    s.measured = measured;
    sample_q.push_back(s);
  endtask

  function automatic data_t rand_value();
    case ($urandom_range(9))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2, 3: return data_t'($urandom);
      default: return data_t'($urandom_range(0, 32'h0020_0000)) - data_t'(32'h0010_0000);
    endcase
  endfunction

  task automatic queue_random(int n);
    data_t t, m;
    repeat (n) begin
      t = rand_value();
      // Half the time the measurement tracks the target, as in a settled loop.
      if ($urandom_range(1))
        m = t + data_t'($urandom_range(0, 32'h0004_0000)) - data_t'(32'h0002_0000);
      else
        m = rand_value();
      push_sample(t, m);
    end
  endtask

  // Sampled at the rising edge, where the handshake signals have settled.
  task automatic drain();
    while (sample_q.size() != 0 || in_tvalid || drive_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idle(idle_e mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 85 : (mode == IDLE_BOTH) ? 27 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 85 : (mode == IDLE_BOTH) ? 27 : 0;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Gains are zero out of reset, so the drive stays at zero.
    push_sample(DATA_MAX, DATA_MIN);
    push_sample(DATA_MIN, DATA_MAX);
    push_sample('0, '0);
    drain();

    write_reg(REG_KP, 32'h0001_0000);
    write_reg(REG_INT_GAIN, 32'h0000_8000);
    write_reg(REG_DERIV_GAIN, 32'h0002_0000);
    write_reg(REG_DERIV_POLE, 32'h0000_8000);
    write_limits(-32'sh0064_0000, 32'h0064_0000, -32'sh000a_0000, 32'h000a_0000);
    push_sample('0, '0);
    push_sample(DATA_MAX, DATA_MIN);
    push_sample(DATA_MIN, DATA_MAX);
    push_sample(DATA_MAX, DATA_MAX);
    push_sample(DATA_MIN, DATA_MIN);
    // Wind the integrator into its upper limit, then back down.
    repeat (6) push_sample(32'sh0005_0000, 32'sh0001_0000);
    repeat (3) push_sample(-32'sh0005_0000, 32'sh0002_0000);
    drain();

    // Full-scale gains, a pole at minus one and both limit pairs crossed.
    write_reg(REG_KP, 32'h7fff_ffff);
    write_reg(REG_INT_GAIN, 32'h7fff_ffff);
    write_reg(REG_DERIV_GAIN, 32'h7fff_ffff);
    write_reg(REG_DERIV_POLE, -32'sh0001_0000);
    write_limits(32'h000a_0000, -32'sh000a_0000, 32'h0005_0000, -32'sh0005_0000);
    push_sample('0, '0);
    push_sample(DATA_MAX, '0);
    push_sample(DATA_MIN, DATA_MAX);
    push_sample(32'sh0001_0000, DATA_MIN);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_idle(idle_e'(p % 4));
      program_random(cfg_style_e'((p / 2) % 4));
      // The sender pauses halfway until every result is back.
      repeat (2) begin
        queue_random(85);
        drain();
      end
    end

    set_idle(IDLE_NONE);
    program_random(CFG_CALM);
    holdoff_req = 1'b1;
    queue_random(60);
    drain();

    repeat (20) @(negedge clk);
    $display("Checked %0d controller updates over %0d register settings,", n_updates,
             n_settings);
    $display("with crossed and extreme limits, saturating gains and long output stalls.");
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", drive_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== pid_controller_step_top.f =====
rtl/pcs_pkg.sv
rtl/pcs_cfg_regs.sv
rtl/pcs_datapath.sv
rtl/pid_controller_step_top.sv
tb/sv/pid_controller_step_top_test.sv
